FILE: src/apq_pkg.sv
// shared types and constants for the aging priority queue
// used by apq_cell and aging_priority_queue_core, no dependencies
`default_nettype none

package apq_pkg;

   localparam int unsigned DEPTH      = 16;
   localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned PRIO_W     = 8;
   localparam int unsigned INTERVAL_W = 4;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(2);

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_ENQUEUED = 2'd0,
      STAT_DEQUEUED = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE = 3'b001,
      FSM_SCAN = 3'b010,
      FSM_DONE = 3'b100
   } fsm_type;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
   } entry_type;

   // running best of the scan wave
   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [VALUE_W-1:0] value;
      idx_type            sel;
   } carry_type;

   // broadcast from the core to every cell
   typedef struct packed {
      logic               enq;
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
      logic               commit;
      logic               age;
      logic [PRIO_W-1:0]  rm_prio;
      idx_type            sel;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: src/apq_cell.sv
// one queue slot: holds an entry, takes part in the max scan wave
// and shifts from its younger neighbor on removal; uses apq_pkg
`default_nettype none

module apq_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire apq_pkg::idx_type      cell_idx,
   input  wire apq_pkg::cell_ctl_type ctl,
   input  wire logic                  prev_valid,
   input  wire apq_pkg::entry_type    next_entry,
   input  wire logic                  token_in,
   input  wire apq_pkg::carry_type    carry_in,
   output apq_pkg::entry_type         entry,
   output logic                       token_out,
   output apq_pkg::carry_type         carry_out
);

   apq_pkg::entry_type entry_ff, entry_in, src;
   apq_pkg::carry_type carry_ff, carry_wave_in;
   logic               token_ff;
   logic               take;
   logic               bump;

   function automatic logic [apq_pkg::PRIO_W-1:0] PRIO_W_ONE(input logic b);
      PRIO_W_ONE = {{(apq_pkg::PRIO_W-1){1'b0}}, b};
   endfunction

   always_comb begin
      take = entry_ff.valid && ((cell_idx == '0) || (entry_ff.prio > carry_in.prio));
      if (token_in && take) begin
         carry_wave_in = '{prio: entry_ff.prio, value: entry_ff.value, sel: cell_idx};
      end else if (token_in) begin
         carry_wave_in = carry_in;
      end else begin
         carry_wave_in = carry_ff;
      end
   end

   always_comb begin
      src      = (cell_idx >= ctl.sel) ? next_entry : entry_ff;
      bump     = ctl.age && (src.prio < ctl.rm_prio);
      entry_in = entry_ff;
      if (ctl.commit) begin
         entry_in      = src;
         entry_in.prio = src.prio + PRIO_W_ONE(bump);
      end else if (ctl.enq && !entry_ff.valid && prev_valid) begin
         entry_in = '{valid: 1'b1, value: ctl.value, prio: ctl.prio};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         token_ff       <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         token_ff       <= token_in;
      end
      entry_ff.value <= entry_in.value;
      entry_ff.prio  <= entry_in.prio;
      carry_ff       <= carry_wave_in;
   end

   assign entry     = entry_ff;
   assign token_out = token_ff;
   assign carry_out = carry_ff;

endmodule

`default_nettype wire

FILE: src/aging_priority_queue_core.sv
// aging priority queue top level: control sequencer, response register
// and a chain of apq_cell slots; uses apq_pkg and apq_cell
//
//   channel  direction  tdata                            tuser
//   req_     in         value[31:0], priority_req[39:32]  cmd[0]
//   rsp_     out        out_value[31:0]                  status[1:0]
//   csr_     in         aging_interval[3:0]              -
//
// enqueue, full and empty replies are loaded into the result register at the accepting edge
// a dequeue sends a compare wave down the cell chain one slot per cycle; a commit step then
// removes the winner, closes the gap and, every aging_interval-th dequeue, ages all slots
// of lower priority at once; a waiting result blocks only the commit and the acceptance of
// an item, never the wave; reset is synchronous and empties the queue, no clearing pass
`default_nettype none

module aging_priority_queue_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // value, priority_req
   input  wire logic [0:0]  req_tuser,   // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // out_value
   output logic [1:0]       rsp_tuser,   // status
   input  wire logic        csr_tvalid,
   output logic             csr_tready,
   input  wire logic [7:0]  csr_tdata    // aging_interval, upper bits unused
);

   localparam int unsigned Depth = apq_pkg::DEPTH;

   apq_pkg::entry_type    entry [Depth];
   apq_pkg::carry_type    carry [Depth];
   logic                  token [Depth];
   apq_pkg::cell_ctl_type ctl;

   apq_pkg::fsm_type                   fsm_ff, fsm_in;
   logic [apq_pkg::INTERVAL_W-1:0]     interval_ff, interval_in;
   logic [apq_pkg::INTERVAL_W-1:0]     tally_ff, tally_in, tally_inc;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [apq_pkg::VALUE_W-1:0]        rsp_data_ff, rsp_data_in;
   apq_pkg::status_type                rsp_stat_ff, rsp_stat_in;
   logic                               scan_start;
   logic                               slot_free;
   logic                               req_fire;
   logic                               age_now;
   apq_pkg::cmd_type                   cmd;

   for (genvar i = 0; i < Depth; i++) begin : g_cell
      logic               prev_valid;
      apq_pkg::entry_type next_entry;
      logic               tok_in;
      apq_pkg::carry_type car_in;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
         assign tok_in     = scan_start;
         assign car_in     = '0;
      end else begin : g_body
         assign prev_valid = entry[i-1].valid;
         assign tok_in     = token[i-1];
         assign car_in     = carry[i-1];
      end

      if (i == Depth - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_mid
         assign next_entry = entry[i+1];
      end

      apq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (apq_pkg::idx_type'(i)),
         .ctl        (ctl),
         .prev_valid (prev_valid),
         .next_entry (next_entry),
         .token_in   (tok_in),
         .carry_in   (car_in),
         .entry      (entry[i]),
         .token_out  (token[i]),
         .carry_out  (carry[i])
      );
   end

   assign cmd        = apq_pkg::cmd_type'(req_tuser[0]);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (fsm_ff == apq_pkg::FSM_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_tready = (fsm_ff == apq_pkg::FSM_IDLE);
   assign tally_inc  = tally_ff + apq_pkg::INTERVAL_W'(1);
   assign age_now    = (tally_inc == interval_ff);

   always_comb begin
      fsm_in       = fsm_ff;
      tally_in     = tally_ff;
      interval_in  = interval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;
      scan_start   = 1'b0;
      ctl          = '0;
      ctl.value    = req_tdata[31:0];
      ctl.prio     = req_tdata[39:32];
      ctl.sel      = carry[Depth-1].sel;
      ctl.rm_prio  = carry[Depth-1].prio;

      if (csr_tvalid && csr_tready) begin
         interval_in = csr_tdata[apq_pkg::INTERVAL_W-1:0];
      end

      case (fsm_ff)
         apq_pkg::FSM_IDLE: begin
            if (req_fire) begin
               if (cmd == apq_pkg::CMD_ENQUEUE) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  if (entry[Depth-1].valid) begin
                     rsp_stat_in = apq_pkg::STAT_FULL;
                  end else begin
                     ctl.enq     = 1'b1;
                     rsp_stat_in = apq_pkg::STAT_ENQUEUED;
                  end
               end else if (!entry[0].valid) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_stat_in  = apq_pkg::STAT_EMPTY;
               end else begin
                  scan_start = 1'b1;
                  fsm_in     = apq_pkg::FSM_SCAN;
               end
            end
         end
         apq_pkg::FSM_SCAN: begin
            if (token[Depth-1]) begin
               fsm_in = apq_pkg::FSM_DONE;
            end
         end
         apq_pkg::FSM_DONE: begin
            if (slot_free) begin
               ctl.commit   = 1'b1;
               ctl.age      = age_now;
               tally_in     = age_now ? '0 : tally_inc;
               rsp_valid_in = 1'b1;
               rsp_data_in  = carry[Depth-1].value;
               rsp_stat_in  = apq_pkg::STAT_DEQUEUED;
               fsm_in       = apq_pkg::FSM_IDLE;
            end
         end
         default: begin
            fsm_in = apq_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= apq_pkg::FSM_IDLE;
         tally_ff     <= '0;
         interval_ff  <= apq_pkg::INTERVAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         tally_ff     <= tally_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

endmodule

`default_nettype wire

FILE: tb/tb_aging_priority_queue_core.sv
// testbench for aging_priority_queue_core: random and directed queue commands
// checked against an in-bench model of the aging queue; needs apq_pkg and the core rtl
`default_nettype none

module tb_aging_priority_queue_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1550;
   localparam int PHASES       = 8;

   typedef struct {
      apq_pkg::cmd_type cmd;
      logic [31:0]      value;
      logic [7:0]       prio;
   } command_type;

   typedef struct {
      logic [31:0]         value;
      apq_pkg::status_type status;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // value, priority_req
   logic [0:0]  req_tuser = '0;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // out_value
   logic [1:0]  rsp_tuser;        // status
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [7:0]  csr_tdata = '0;   // aging_interval, upper bits unused

   command_type command_backlog[$];
   reply_type   predicted_replies[$];
   command_type next_command;
   logic        req_fire = 1'b0;
   logic        steady_mode = 1'b0;

   logic [31:0] slot_value[apq_pkg::DEPTH];
   logic [7:0]  slot_prio[apq_pkg::DEPTH];
   int          slot_count = 0;
   logic [3:0]  dequeue_tally = '0;
   logic [3:0]  interval_model = apq_pkg::INTERVAL_RESET;

   int          error_count = 0;
   int          enqueue_total = 0;
   int          dequeue_total = 0;
   int          full_total = 0;
   int          empty_total = 0;
   int          aging_total = 0;
   int          stall_cycles = 0;

   aging_priority_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always #4 clock = ~clock;

   function automatic reply_type apply_queue_command(command_type item);
      reply_type   r;
      int          sel;
      logic [7:0]  best;
      logic [7:0]  removed;
      r.value = '0;
      if (item.cmd == apq_pkg::CMD_ENQUEUE) begin
         if (slot_count >= apq_pkg::DEPTH) begin
            r.status = apq_pkg::STAT_FULL;
            full_total++;
         end else begin
            slot_value[slot_count] = item.value;
            slot_prio[slot_count]  = item.prio;
            slot_count++;
            r.status = apq_pkg::STAT_ENQUEUED;
            enqueue_total++;
         end
      end else if (slot_count == 0) begin
         r.status = apq_pkg::STAT_EMPTY;
         empty_total++;
      end else begin
         sel  = 0;
         best = '0;
         for (int i = 0; i < slot_count; i++) begin
            if (slot_prio[i] > best) begin
               best = slot_prio[i];
               sel  = i;
            end
         end
         r.value = slot_value[sel];
         removed = slot_prio[sel];
         for (int i = sel; i + 1 < slot_count; i++) begin
            slot_value[i] = slot_value[i+1];
            slot_prio[i]  = slot_prio[i+1];
         end
         slot_count--;
         dequeue_tally = dequeue_tally + 4'd1;
         if (dequeue_tally == interval_model) begin
            for (int i = 0; i < slot_count; i++) begin
               if (slot_prio[i] < removed) slot_prio[i] = slot_prio[i] + 8'd1;
            end
            dequeue_tally = '0;
            aging_total++;
         end
         r.status = apq_pkg::STAT_DEQUEUED;
         dequeue_total++;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
      error_count++;
   endtask

   // driver
   always @(negedge clock) begin
      rsp_tready <= steady_mode || ($urandom_range(99, 0) >= 12);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (command_backlog.size() > 0 && (steady_mode || $urandom_range(99, 0) >= 12)) begin
            next_command = command_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {next_command.prio, next_command.value};
            req_tuser  <= next_command.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      reply_type   want;
      command_type seen;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_replies.size() == 0) begin
               report_mismatch("unexpected item, status", '0, 32'(rsp_tuser));
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_tuser));
               if (rsp_tdata !== want.value)
                  report_mismatch("out_value", want.value, rsp_tdata);
            end
         end
         if (csr_tvalid && csr_tready) interval_model = csr_tdata[3:0];
         if (req_tvalid && req_tready) begin
            seen.cmd   = apq_pkg::cmd_type'(req_tuser[0]);
            seen.value = req_tdata[31:0];
            seen.prio  = req_tdata[39:32];
            predicted_replies.push_back(apply_queue_command(seen));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_tvalid && csr_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", stall_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic push_command(apq_pkg::cmd_type cmd, logic [31:0] value, logic [7:0] prio);
      command_type item;
      item.cmd   = cmd;
      item.value = value;
      item.prio  = prio;
      command_backlog.push_back(item);
   endtask

   task automatic wait_for_drain();
      while (command_backlog.size() != 0 || req_tvalid || predicted_replies.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_aging_interval(logic [3:0] interval);
      wait_for_drain();
      repeat (2) @(negedge clock);
      csr_tdata  <= {4'($urandom), interval};
      csr_tvalid <= 1'b1;
      do @(posedge clock); while (!csr_tready);
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   // bursts leaning toward fill or drain, or balanced, so full, empty and deep aging all show up
   task automatic queue_random_traffic(int count);
      int left;
      int burst;
      int enq_pct;
      int prio_mode;
      logic [7:0] prio;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(40, 4);
         if (burst > left) burst = left;
         case ($urandom_range(2, 0))
            0: enq_pct = 80;
            1: enq_pct = 20;
            default: enq_pct = 50;
         endcase
         prio_mode = $urandom_range(3, 0);
         repeat (burst) begin
            case (prio_mode)
               0: prio = 8'($urandom_range(3, 0));
               1: prio = 8'($urandom);
               2: prio = 8'd0;
               default: prio = $urandom_range(1, 0) ? 8'($urandom_range(1, 0))
                                                    : 8'(254 + $urandom_range(1, 0));
            endcase
            push_command(($urandom_range(99, 0) < enq_pct) ? apq_pkg::CMD_ENQUEUE
                                                           : apq_pkg::CMD_DEQUEUE,
                         $urandom, prio);
         end
         left -= burst;
      end
   endtask

   initial begin
      logic [3:0] phase_interval[PHASES];
      logic [7:0] fill_prio[15];
      phase_interval = '{4'd1, 4'd15, 4'd3, 4'd0, 4'd8, 4'd2, 4'd15, 4'd1};
      fill_prio = '{8'd255, 8'd0, 8'd3, 8'd3, 8'd1, 8'd255, 8'd2, 8'd0,
                    8'd128, 8'd127, 8'd3, 8'd1, 8'd0, 8'd254, 8'd3};
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // empty, all-zero tie, fill to full, overflow, then serve a few
      push_command(apq_pkg::CMD_DEQUEUE, 32'hffff_ffff, 8'hff);
      push_command(apq_pkg::CMD_ENQUEUE, 32'h8000_0000, 8'd0);
      push_command(apq_pkg::CMD_ENQUEUE, 32'h7fff_ffff, 8'd0);
      push_command(apq_pkg::CMD_DEQUEUE, 32'h0, 8'd0);
      for (int i = 0; i < 15; i++) begin
         push_command(apq_pkg::CMD_ENQUEUE,
                      (i == 0) ? 32'h0 : (i == 1) ? 32'hffff_ffff : $urandom,
                      fill_prio[i]);
      end
      push_command(apq_pkg::CMD_ENQUEUE, 32'h1234_5678, 8'd200);
      repeat (5) push_command(apq_pkg::CMD_DEQUEUE, $urandom, 8'($urandom));

      for (int p = 0; p < PHASES; p++) begin
         write_aging_interval(phase_interval[p]);
         steady_mode = (p == 4);
         queue_random_traffic(RANDOM_ITEMS / PHASES);
      end
      steady_mode = 1'b0;

      wait_for_drain();
      repeat (40) @(negedge clock);
      $display("covered %0d enqueues, %0d dequeues, %0d full and %0d empty replies",
               enqueue_total, dequeue_total, full_total, empty_total);
      $display("%0d aging passes over %0d interval settings, one phase without idle cycles",
               aging_total, PHASES + 1);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
src/apq_pkg.sv
src/apq_cell.sv
src/aging_priority_queue_core.sv
tb/tb_aging_priority_queue_core.sv
